// ----- src/bs_pkg.sv -----
// ----------------------------------------------------------------------------
// Bitonic sorter package
// Shared sizes, the write source select and the control bundle that the
// sequencer hands to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bs_pkg;

	localparam int NUM_ELEMENTS = 16;
	localparam int DATA_W       = 32;
	localparam int IDX_W        = $clog2(NUM_ELEMENTS);
	localparam int KEXP_W       = $clog2(IDX_W + 1);

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [IDX_W-1:0]         idx_t;

	typedef enum logic [1:0] {
		WSEL_IN     = 2'd0,
		WSEL_FIRST  = 2'd1,
		WSEL_SECOND = 2'd2
	} wsel_t;

	typedef struct packed {
		logic  we;
		idx_t  waddr;
		wsel_t wsel;
		logic  re;
		idx_t  raddr_a;
		idx_t  raddr_b;
		logic  up;
	} ctrl_t;

endpackage

`default_nettype wire

// ----- src/bs_cex.sv -----
// ----------------------------------------------------------------------------
// Bitonic sorter compare-exchange unit
// Orders one pair of signed elements; an ascending pair puts the smaller
// value first, a descending pair the larger.
// ----------------------------------------------------------------------------
`default_nettype none

module bs_cex
	import bs_pkg::*;
(
	input  data_t a,
	input  data_t b,
	input  logic  up,
	output data_t first,
	output data_t second
);

	logic exch;

	always_comb begin
		if (up) begin
			exch = a > b;
		end else begin
			exch = b > a;
		end
		first  = exch ? b : a;
		second = exch ? a : b;
	end

endmodule

`default_nettype wire

// ----- src/bs_seq.sv -----
// ----------------------------------------------------------------------------
// Bitonic sorter sequencer
// Counts the load, walks the network pair by pair and steps the emit.
// ----------------------------------------------------------------------------
`default_nettype none

module bs_seq
	import bs_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	output logic  out_valid,
	input  logic  out_stall,
	output logic  out_last,
	output ctrl_t ctrl
);

	typedef enum logic [5:0] {
		S_LOAD  = 6'b000001,
		S_RD    = 6'b000010,
		S_WR1   = 6'b000100,
		S_WR2   = 6'b001000,
		S_EMRD  = 6'b010000,
		S_EMOUT = 6'b100000
	} state_t;

	localparam idx_t IDX_LAST  = IDX_W'(NUM_ELEMENTS - 1);
	localparam idx_t PAIR_LAST = IDX_W'(NUM_ELEMENTS / 2 - 1);
	localparam logic [KEXP_W-1:0] KEXP_LAST = KEXP_W'(IDX_W);

	state_t            state_q;
	idx_t              cnt_q;
	idx_t              m_q;
	logic [KEXP_W-1:0] kexp_q;
	logic [KEXP_W-1:0] jexp_q;

	logic [IDX_W:0] m_ext;
	logic [IDX_W:0] pos_bit;
	logic [IDX_W:0] low_mask;
	logic [IDX_W:0] i_ext;
	logic [IDX_W:0] k_bit;
	idx_t           addr_a;
	idx_t           addr_b;

	always_comb begin
		m_ext    = {1'b0, m_q};
		pos_bit  = (IDX_W + 1)'(1) << jexp_q;
		low_mask = pos_bit - (IDX_W + 1)'(1);
		i_ext    = ((m_ext & ~low_mask) << 1) | (m_ext & low_mask);
		k_bit    = (IDX_W + 1)'(1) << kexp_q;
		addr_a   = i_ext[IDX_W-1:0];
		addr_b   = addr_a | pos_bit[IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			cnt_q   <= '0;
			m_q     <= '0;
			kexp_q  <= KEXP_W'(1);
			jexp_q  <= '0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (in_valid) begin
						cnt_q <= cnt_q + IDX_W'(1);
						if (cnt_q == IDX_LAST) begin
							state_q <= S_RD;
							m_q     <= '0;
							kexp_q  <= KEXP_W'(1);
							jexp_q  <= '0;
						end
					end
				end
				S_RD: begin
					state_q <= S_WR1;
				end
				S_WR1: begin
					state_q <= S_WR2;
				end
				S_WR2: begin
					state_q <= S_RD;
					if (m_q == PAIR_LAST) begin
						m_q <= '0;
						if (jexp_q == '0) begin
							if (kexp_q == KEXP_LAST) begin
								state_q <= S_EMRD;
							end else begin
								kexp_q <= kexp_q + KEXP_W'(1);
								jexp_q <= kexp_q;
							end
						end else begin
							jexp_q <= jexp_q - KEXP_W'(1);
						end
					end else begin
						m_q <= m_q + IDX_W'(1);
					end
				end
				S_EMRD: begin
					state_q <= S_EMOUT;
				end
				S_EMOUT: begin
					if (!out_stall) begin
						cnt_q   <= cnt_q + IDX_W'(1);
						state_q <= (cnt_q == IDX_LAST) ? S_LOAD : S_EMRD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	always_comb begin
		ctrl.we      = 1'b0;
		ctrl.waddr   = addr_a;
		ctrl.wsel    = WSEL_FIRST;
		ctrl.re      = 1'b0;
		ctrl.raddr_a = addr_a;
		ctrl.raddr_b = addr_b;
		ctrl.up      = (i_ext & k_bit) == '0;
		unique case (state_q)
			S_LOAD: begin
				ctrl.we    = in_valid;
				ctrl.waddr = cnt_q;
				ctrl.wsel  = WSEL_IN;
			end
			S_RD: begin
				ctrl.re = 1'b1;
			end
			S_WR1: begin
				ctrl.we = 1'b1;
			end
			S_WR2: begin
				ctrl.we    = 1'b1;
				ctrl.waddr = addr_b;
				ctrl.wsel  = WSEL_SECOND;
			end
			S_EMRD: begin
				ctrl.re      = 1'b1;
				ctrl.raddr_a = cnt_q;
			end
			default: begin
			end
		endcase
	end

	assign in_stall  = state_q != S_LOAD;
	assign out_valid = state_q == S_EMOUT;
	assign out_last  = cnt_q == IDX_LAST;

	// A result is never offered while an element can be loaded.
	assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> in_stall)
		else $error("result offered during load");

	// Loading the final element starts the network.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && cnt_q == IDX_LAST) |=> (state_q == S_RD))
		else $error("network did not start after the final element");

	// The transfer of the last result reopens the input.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && out_last) |=> !in_stall)
		else $error("input not reopened after the last result");

	// The two elements of a pair are always distinct entries.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD) |-> (addr_a != addr_b))
		else $error("compare-exchange pair addresses collide");

endmodule

`default_nettype wire

// ----- src/bitonic_sorter.sv -----
// ----------------------------------------------------------------------------
// Bitonic sorter
// Loads a batch of signed elements, sorts them with a bitonic network on one
// compare-exchange unit and streams them out in ascending order.
// ----------------------------------------------------------------------------
// Load: one element per cycle; in_stall stays low until the batch is full.
// Sort: NUM_ELEMENTS/2 * log2(N) * (log2(N)+1)/2 pairs, each done as read
// both, write first, write second, set by the single write port of the
// element store.
// Emit: a result is read from the store and held while out_stall is high.
// Reset clears the sequencer and load count; the store content is undefined.
// ----------------------------------------------------------------------------
`default_nettype none

module bitonic_sorter
	import bs_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  data_t value,
	output logic  out_valid,
	input  logic  out_stall,
	output data_t sorted_value,
	output logic  last
);

	ctrl_t ctrl;
	data_t mem_q [NUM_ELEMENTS];
	data_t rdata_a_q;
	data_t rdata_b_q;
	data_t second_q;
	data_t cex_first;
	data_t cex_second;
	data_t wdata;

	bs_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_last  (last),
		.ctrl      (ctrl)
	);

	bs_cex u_cex (
		.a      (rdata_a_q),
		.b      (rdata_b_q),
		.up     (ctrl.up),
		.first  (cex_first),
		.second (cex_second)
	);

	always_comb begin
		case (ctrl.wsel)
			WSEL_IN:     wdata = value;
			WSEL_FIRST:  wdata = cex_first;
			WSEL_SECOND: wdata = second_q;
			default:     wdata = value;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.we) begin
			mem_q[ctrl.waddr] <= wdata;
		end
		if (ctrl.re) begin
			rdata_a_q <= mem_q[ctrl.raddr_a];
			rdata_b_q <= mem_q[ctrl.raddr_b];
		end
		if (ctrl.we && ctrl.wsel == WSEL_FIRST) begin
			second_q <= cex_second;
		end
	end

	assign sorted_value = rdata_a_q;

endmodule

`default_nettype wire
